FILE: rtl/pwlt_pkg.sv
// ----------------------------------------------------------------------------
// pwlt_pkg
// Shared constants and types for the piecewise-linear axis timeline core.
// ----------------------------------------------------------------------------
package pwlt_pkg;

   localparam int MAX_POINTS = 16;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = $clog2(MAX_POINTS);

   localparam logic [1:0] REQ_QUERY   = 2'd0;
   localparam logic [1:0] REQ_SET_POS = 2'd1;
   localparam logic [1:0] REQ_SET_VEL = 2'd2;
   localparam logic [1:0] REQ_ADVANCE = 2'd3;

   typedef struct packed {
      logic [31:0] btime;
      logic [31:0] bpos;
      logic [31:0] bvel;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   // pos + vel * (t - btime)
   typedef struct packed {
      logic        start;
      entry_type   base;
      logic [31:0] t;
   } ip_req_type;

endpackage

FILE: rtl/piecewise_linear_axis_timeline_core.sv
// A query or set position searches the table one entry read per cycle, and a query then
// runs the multiply-add where needed; a set velocity first checks the last point, then searches
// and runs the multiply-add; an advance searches, then moves the kept entries one per cycle.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset clears the point count and control state; store contents stay undefined.
// ----------------------------------------------------------------------------
// piecewise_linear_axis_timeline_core
// Breakpoint table sequencer with query, set position, set velocity, advance.
// ----------------------------------------------------------------------------
module piecewise_linear_axis_timeline_core
   import pwlt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_event_time,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position,
   output logic [4:0]         rsp_points_used,
   output logic               rsp_table_full
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LAST_RD, ST_LAST_CHK, ST_SEARCH, ST_DISPATCH, ST_INTERP_WAIT,
      ST_APPEND, ST_SHIFT, ST_FIX_WAIT, ST_FIX_WR, ST_RESP
   } state_type;

   state_type   state_ff;
   logic [1:0]  type_ff;
   logic [31:0] t_ff, val_ff, pos_out_ff, newpos_ff;
   logic [CNT_W-1:0] count_ff, k_ff, issue_ff, src_ff, dst_ff;
   logic        pend_ff, full_ff;
   entry_type   prev_ff, first_ff;

   logic        rsp_valid_ff, rsp_full_ff;
   logic [31:0] rsp_pos_ff;
   logic [4:0]  rsp_used_ff;

   mem_req_type mem_req;
   entry_type   rd_data;
   ip_req_type  ip_req;
   logic        ip_done;
   logic [31:0] ip_result;

   logic pass, search_end, search_rd, shift_rd, last_rd, shift_end, fix_needed;
   entry_type shifted;

   pwlt_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pwlt_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .ip_req (ip_req),
      .done   (ip_done),
      .result (ip_result)
   );

   assign pass       = $signed(rd_data.btime) <= $signed(t_ff);
   assign search_end = pend_ff && (!pass || (k_ff + 1'b1 == count_ff));
   assign search_rd  = (state_ff == ST_SEARCH) && (issue_ff < count_ff) && !search_end;
   assign shift_rd   = (state_ff == ST_SHIFT) && (src_ff < count_ff);
   assign last_rd    = (state_ff == ST_LAST_RD) && (count_ff != '0);
   assign shift_end  = (state_ff == ST_SHIFT) && (src_ff >= count_ff) && !pend_ff;
   assign fix_needed = (dst_ff != '0) && first_ff.btime[31];

   always_comb begin
      shifted       = rd_data;
      shifted.btime = rd_data.btime - t_ff;
   end

   always_comb begin
      mem_req.re    = search_rd || shift_rd || last_rd;
      mem_req.raddr = last_rd   ? IDX_W'(count_ff - 1'b1) :
                      search_rd ? issue_ff[IDX_W-1:0] : src_ff[IDX_W-1:0];
      mem_req.we    = 1'b0;
      mem_req.waddr = k_ff[IDX_W-1:0];
      mem_req.wdata = '0;
      case (state_ff)
         ST_APPEND: begin
            mem_req.we          = 1'b1;
            mem_req.wdata.btime = t_ff;
            if (type_ff == REQ_SET_POS) begin
               mem_req.wdata.bpos = val_ff;
               mem_req.wdata.bvel = (k_ff != '0) ? prev_ff.bvel : 32'd0;
            end else begin
               mem_req.wdata.bpos = newpos_ff;
               mem_req.wdata.bvel = val_ff;
            end
         end
         ST_SHIFT: begin
            mem_req.we    = pend_ff;
            mem_req.waddr = dst_ff[IDX_W-1:0];
            mem_req.wdata = shifted;
         end
         ST_FIX_WR: begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = '0;
            mem_req.wdata.btime = 32'd0;
            mem_req.wdata.bpos  = newpos_ff;
            mem_req.wdata.bvel  = first_ff.bvel;
         end
         default: begin
            mem_req.we = 1'b0;
         end
      endcase
   end

   always_comb begin
      ip_req.start = 1'b0;
      ip_req.base  = prev_ff;
      ip_req.t     = t_ff;
      if (state_ff == ST_DISPATCH && k_ff != '0 &&
          (type_ff == REQ_QUERY ||
           (type_ff == REQ_SET_VEL && k_ff != CNT_W'(MAX_POINTS)))) begin
         ip_req.start = 1'b1;
      end else if (shift_end && fix_needed) begin
         // first point now in the past: pull it back to time zero
         ip_req.start = 1'b1;
         ip_req.base  = first_ff;
         ip_req.t     = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         // in ST_RESP the output register is reloaded instead
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  type_ff    <= req_type;
                  t_ff       <= req_event_time;
                  val_ff     <= req_new_value;
                  full_ff    <= 1'b0;
                  pos_out_ff <= 32'd0;
                  k_ff       <= '0;
                  issue_ff   <= '0;
                  pend_ff    <= 1'b0;
                  if (req_type == REQ_SET_VEL) begin
                     state_ff <= ST_LAST_RD;
                  end else if (count_ff == '0) begin
                     state_ff <= ST_DISPATCH;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_LAST_RD: begin
               if (count_ff != '0) begin
                  state_ff <= ST_LAST_CHK;
               end else if (val_ff == 32'd0) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_LAST_CHK: begin
               if (pass && rd_data.bvel == val_ff) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               pend_ff <= search_rd;
               if (search_rd) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (pend_ff) begin
                  if (pass) begin
                     prev_ff <= rd_data;
                     k_ff    <= k_ff + 1'b1;
                  end else if (k_ff == '0) begin
                     first_ff <= rd_data;
                  end
               end
               if (search_end) begin
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               pend_ff <= 1'b0;
               case (type_ff)
                  REQ_QUERY: begin
                     if (k_ff != '0) begin
                        state_ff <= ST_INTERP_WAIT;
                     end else begin
                        pos_out_ff <= (count_ff != '0) ? first_ff.bpos : 32'd0;
                        state_ff   <= ST_RESP;
                     end
                  end
                  REQ_SET_POS: begin
                     if (k_ff == CNT_W'(MAX_POINTS)) begin
                        full_ff  <= 1'b1;
                        state_ff <= ST_RESP;
                     end else begin
                        state_ff <= ST_APPEND;
                     end
                  end
                  REQ_SET_VEL: begin
                     if (k_ff == CNT_W'(MAX_POINTS)) begin
                        full_ff  <= 1'b1;
                        state_ff <= ST_RESP;
                     end else if (k_ff != '0) begin
                        state_ff <= ST_INTERP_WAIT;
                     end else begin
                        newpos_ff <= 32'd0;
                        state_ff  <= ST_APPEND;
                     end
                  end
                  default: begin
                     // advance: keep the last point at or before t
                     src_ff <= (k_ff != '0) ? k_ff - 1'b1 : '0;
                     dst_ff <= '0;
                     state_ff <= (count_ff == '0) ? ST_RESP : ST_SHIFT;
                  end
               endcase
            end
            ST_INTERP_WAIT: begin
               if (ip_done) begin
                  if (type_ff == REQ_QUERY) begin
                     pos_out_ff <= ip_result;
                     state_ff   <= ST_RESP;
                  end else begin
                     newpos_ff <= ip_result;
                     state_ff  <= ST_APPEND;
                  end
               end
            end
            ST_APPEND: begin
               count_ff <= k_ff + 1'b1;
               state_ff <= ST_RESP;
            end
            ST_SHIFT: begin
               pend_ff <= shift_rd;
               if (shift_rd) begin
                  src_ff <= src_ff + 1'b1;
               end
               if (pend_ff) begin
                  dst_ff <= dst_ff + 1'b1;
                  if (dst_ff == '0) begin
                     first_ff <= shifted;
                  end
               end
               if (shift_end) begin
                  count_ff <= dst_ff;
                  state_ff <= fix_needed ? ST_FIX_WAIT : ST_RESP;
               end
            end
            ST_FIX_WAIT: begin
               if (ip_done) begin
                  newpos_ff <= ip_result;
                  state_ff  <= ST_FIX_WR;
               end
            end
            ST_FIX_WR: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_ff   <= pos_out_ff;
                  rsp_used_ff  <= 5'(count_ff);
                  rsp_full_ff  <= full_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_points_used = rsp_used_ff;
   assign rsp_table_full  = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above table size");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (k_ff <= count_ff) && (k_ff <= issue_ff))
      else $error("search index ran past the table");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
      else $error("read and write to the same entry in one cycle");

   a_ip_done_waited: assert property (@(posedge clock) disable iff (reset)
      ip_done |-> (state_ff == ST_INTERP_WAIT || state_ff == ST_FIX_WAIT))
      else $error("multiply-add result with nobody waiting");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP) && (state_ff == ST_IDLE))
      else $error("result queued outside the response state");

endmodule

FILE: rtl/pwlt_mem.sv
// ----------------------------------------------------------------------------
// pwlt_mem
// Breakpoint store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pwlt_mem
   import pwlt_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type mem_ff [MAX_POINTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pwlt_interp.sv
// ----------------------------------------------------------------------------
// pwlt_interp
// Three-stage multiply-add: result = pos + vel * (t - btime), wrapping.
// ----------------------------------------------------------------------------
module pwlt_interp
   import pwlt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ip_req_type  ip_req,
   output logic        done,
   output logic [31:0] result
);

   logic        v1_ff, v2_ff, done_ff;
   logic [31:0] diff_ff, vel_ff, pos1_ff, pos2_ff, prod_ff, res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= ip_req.start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      diff_ff <= ip_req.t - ip_req.base.btime;
      vel_ff  <= ip_req.base.bvel;
      pos1_ff <= ip_req.base.bpos;
      prod_ff <= vel_ff * diff_ff;
      pos2_ff <= pos1_ff;
      res_ff  <= pos2_ff + prod_ff;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
